>>> rtl/swat_pkg.sv
// shared constants, types and codes for the send window ack tracker
package swat_pkg;

  localparam int WINDOW_SIZE_DEF = 16;
  localparam int THREADS_DEF     = 4;

  localparam int SEQ_W     = 32;
  localparam int THREAD_W  = 2;
  localparam int THRESH_W  = 4;
  localparam int COUNT_W   = 5;
  localparam int IN_USER_W = 3;
  localparam int OUT_W     = 16;

  localparam logic [THRESH_W-1:0] DUP_THRESH_RESET = 4'd3;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // per-cycle control of one window cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/swat_cell.sv
// one window slot position, holding that slot for every thread
module swat_cell #(
  parameter int THREADS = swat_pkg::THREADS_DEF,
  parameter int TW      = 2
) (
  input  logic                     clk,
  input  logic [TW-1:0]            thread,
  input  swat_pkg::cell_ctl_t      ctl,
  input  logic [swat_pkg::SEQ_W-1:0] load_data,
  input  logic [swat_pkg::SEQ_W-1:0] next_data,
  output logic [swat_pkg::SEQ_W-1:0] cur_data
);
  import swat_pkg::*;

  logic [SEQ_W-1:0] slot [THREADS];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot[thread] <= load_data;
    end else if (ctl.shift) begin
      // take the entry from the neighbor behind, moving the window forward
      slot[thread] <= next_data;
    end
  end

  assign cur_data = slot[thread];

endmodule

>>> rtl/send_window_ack_tracker.sv
// top level: per-thread send window, ack search and duplicate ack detection
//
// Input channel s_*: one transaction is a send (kind 0) or an ack (kind 1) for
// one sender thread. Output channel m_*: exactly one result transaction per
// input transaction, in order. cfg_*: write of the duplicate ack threshold,
// taken in any cycle (cfg_ready is high whenever rst is low), meant to change while idle.
//
// The window is a row of cells, one per slot position; an ack releases the
// front entry one slot per cycle while it does not match, every cell handing
// its entry to the one in front. A new transaction is taken only in the idle
// state, so each transaction is finished before the next is accepted. The
// result is registered and appears in the cycle after the last step of its
// transaction.
//
// A synchronous reset empties all windows, clears the last ack numbers and
// duplicate counts and sets the threshold to 3. When the receiver stalls, the
// result waits in the output register; the next transaction is still taken
// and worked on, and its final step waits until the output register is free.
module send_window_ack_tracker #(
  parameter int WINDOW_SIZE = swat_pkg::WINDOW_SIZE_DEF,
  parameter int THREADS     = swat_pkg::THREADS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swat_pkg::SEQ_W-1:0]      s_tdata,   // seq_or_ack[31:0]
  input  logic [swat_pkg::IN_USER_W-1:0]  s_tuser,   // kind[0], thread_id[2:1]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // accepted[0], released[5:1], free_slots[10:6], fast_retransmit[11],
  // restart_timer[12], window_empty[13], zero[15:14]
  output logic [swat_pkg::OUT_W-1:0]      m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swat_pkg::THRESH_W-1:0]   cfg_data
);
  import swat_pkg::*;

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int OW = $clog2(WINDOW_SIZE + 1);

  state_t state, state_next;

  logic [THRESH_W-1:0] dup_thresh;

  logic             item_kind;
  logic [TW-1:0]    item_th;
  logic [SEQ_W-1:0] item_num;

  logic [OW-1:0]       occ      [THREADS];
  logic [SEQ_W-1:0]    last_ack [THREADS];
  logic [THRESH_W-1:0] dup_cnt  [THREADS];
  logic [OW-1:0]       rel_cnt;

  logic [TW-1:0]    in_th;
  logic [OW-1:0]    cur_occ;
  logic             room;
  logic             out_free;
  logic             scan_more;
  logic             finish;
  logic             do_shift;
  logic             do_append;
  logic [SEQ_W-1:0] front;

  logic [THRESH_W-1:0] dup_inc;
  logic                is_dup;
  logic                fire;
  logic [OW-1:0]       occ_after;
  logic [31:0]         free_wide;
  logic [31:0]         rel_wide;
  logic [OUT_W-1:0]    result_word;

  logic [SEQ_W-1:0] cell_data [WINDOW_SIZE];

  // thread id modulo the thread count; the id is below 4, so a few
  // subtract steps suffice
  always_comb begin
    int v;
    v = int'(s_tuser[THREAD_W:1]);
    for (int i = 0; i < 4; i++) begin
      if (v >= THREADS) begin
        v = v - THREADS;
      end
    end
    in_th = TW'(v);
  end

  assign cfg_ready = !rst;

  assign cur_occ   = occ[item_th];
  assign room      = (cur_occ < OW'(WINDOW_SIZE));
  assign out_free  = !m_tvalid || m_tready;
  assign front     = cell_data[0];
  assign scan_more = (cur_occ != '0) && (front != item_num);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    finish    = 1'b0;
    do_shift  = 1'b0;
    do_append = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
      end
      ST_EXEC: begin
        if (item_kind == KIND_SEND) begin
          finish    = out_free;
          do_append = out_free && room;
        end else begin
          do_shift = scan_more;
          finish   = !scan_more && out_free;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_thresh <= DUP_THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dup_thresh <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_kind <= s_tuser[0];
      item_th   <= in_th;
      item_num  <= s_tdata;
    end
  end

  // duplicate ack detection, applied when the ack completes
  assign is_dup  = (item_num == last_ack[item_th]);
  assign dup_inc = dup_cnt[item_th] + 1'b1;
  assign fire    = is_dup && (dup_inc == dup_thresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < THREADS; t++) begin
        occ[t]      <= '0;
        last_ack[t] <= '0;
        dup_cnt[t]  <= '0;
      end
    end else begin
      if (do_append) begin
        occ[item_th] <= cur_occ + 1'b1;
      end else if (do_shift) begin
        occ[item_th] <= cur_occ - 1'b1;
      end
      if (finish && item_kind == KIND_ACK) begin
        if (!is_dup) begin
          last_ack[item_th] <= item_num;
          dup_cnt[item_th]  <= '0;
        end else if (fire) begin
          dup_cnt[item_th] <= '0;
        end else begin
          dup_cnt[item_th] <= dup_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rel_cnt <= '0;
    end else if (do_shift) begin
      rel_cnt <= rel_cnt + 1'b1;
    end
  end

  assign occ_after = (item_kind == KIND_SEND && room) ? cur_occ + 1'b1 : cur_occ;
  assign free_wide = 32'(WINDOW_SIZE) - 32'(occ_after);
  assign rel_wide  = 32'(rel_cnt);

  always_comb begin
    result_word       = '0;
    result_word[10:6] = free_wide[COUNT_W-1:0];
    if (item_kind == KIND_SEND) begin
      result_word[0] = room;
    end else begin
      result_word[0]   = 1'b1;
      result_word[5:1] = rel_wide[COUNT_W-1:0];
      result_word[11]  = fire;
      result_word[12]  = (rel_cnt != '0) && (cur_occ != '0);
      result_word[13]  = (rel_cnt != '0) && (cur_occ == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= result_word;
    end
  end

  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
    cell_ctl_t        ctl;
    logic [SEQ_W-1:0] next_data;

    assign ctl.load  = do_append && (cur_occ == OW'(k));
    assign ctl.shift = do_shift;

    if (k == WINDOW_SIZE - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_body
      assign next_data = cell_data[k + 1];
    end

    swat_cell #(
      .THREADS (THREADS),
      .TW      (TW)
    ) u_cell (
      .clk       (clk),
      .thread    (item_th),
      .ctl       (ctl),
      .load_data (item_num),
      .next_data (next_data),
      .cur_data  (cell_data[k])
    );
  end

endmodule
